/* rtl/triangular_noise_generator_unit_macros.svh */
// ----------------------------------------------------------------------------
// Triangular noise generator assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGULAR_NOISE_GENERATOR_UNIT_MACROS_SVH
`define TRIANGULAR_NOISE_GENERATOR_UNIT_MACROS_SVH

// Checked outside reset only.
`define TNG_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define TNG_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tng_pkg.sv */
// ----------------------------------------------------------------------------
// Triangular noise generator package
// Types, codes and arithmetic constants shared by the noise generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tng_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SCALE_W    = 31;
    localparam int MAG_W      = 31;
    localparam int STATE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [STATE_W-1:0] LCG_MUL      = 32'd1664525;
    localparam logic [STATE_W-1:0] LCG_ADD      = 32'd1013904223;
    localparam logic [STATE_W-1:0] SEED_RESET   = 32'd1;
    localparam logic [STATE_W-1:0] TRI_OFFSET   = 32'd1073741823;
    localparam logic [14:0]        SAMPLE_LIMIT = 15'd32767;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE  = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LCG1,
        ST_LCG2,
        ST_AMP,
        ST_MUL,
        ST_SAT
    } tng_state_t;

    typedef struct packed {
        logic capture;
        logic lcg_first;
        logic lcg_second;
        logic amp;
        logic mul;
        logic load_out;
    } tng_cmd_t;

    function automatic logic [STATE_W-1:0] lcg_step(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] p;
        p = s * LCG_MUL;
        return p + LCG_ADD;
    endfunction

endpackage

`default_nettype wire

/* rtl/tng_ctrl.sv */
// ----------------------------------------------------------------------------
// Triangular noise generator controller
// Sequences one request through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tng_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tng_pkg::tng_cmd_t     cmd
);
    import tng_pkg::*;

    tng_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LCG1;
                end
            end
            ST_LCG1: begin
                cmd.lcg_first = 1'b1;
                state_next    = ST_LCG2;
            end
            ST_LCG2: begin
                cmd.lcg_second = 1'b1;
                state_next     = ST_AMP;
            end
            ST_AMP: begin
                cmd.amp    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                // hold here until the output register frees up
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/tng_datapath.sv */
// ----------------------------------------------------------------------------
// Triangular noise generator datapath
// Config registers, generator state, triangle sum, scale multiply, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module tng_datapath #(
    parameter int SCALE_FRAC_BITS = 44
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire tng_pkg::tng_cmd_t                  cmd,
    input  wire logic                               cfg_write,
    input  wire logic [tng_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tng_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_frame_end,
    output logic signed [tng_pkg::SAMPLE_W-1:0]     m_noise_sample,
    output logic                                    m_frame_last
);
    import tng_pkg::*;

    localparam int PROD_W = 2 * MAG_W;

    logic [SCALE_W-1:0]  scale_reg;
    logic [STATE_W-1:0]  gen_state_reg, gen_state_next;
    logic [STATE_W-1:0]  r1_reg;
    logic                frame_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                frame_last_reg;

    logic [STATE_W-1:0]  tri_sum;
    logic                tri_neg;
    logic [STATE_W-1:0]  tri_mag;
    logic [PROD_W-1:0]   quot;
    logic [14:0]         clip_mag;
    logic [SAMPLE_W-1:0] clip_ext;

    // control-free config, and generator state stepped on controller commands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= '0;
            gen_state_reg <= SEED_RESET;
        end else begin
            if (cfg_write && cfg_index == REG_NOISE_SCALE) begin
                scale_reg <= cfg_data[SCALE_W-1:0];
            end
            gen_state_reg <= gen_state_next;
        end
    end

    always_comb begin
        gen_state_next = gen_state_reg;
        if (cfg_write && cfg_index == REG_SEED_VALUE) begin
            gen_state_next = cfg_data[STATE_W-1:0];
        end else if (cmd.lcg_first || cmd.lcg_second) begin
            gen_state_next = lcg_step(gen_state_reg);
        end
    end

    // triangle: two quarter-range uniforms summed, centered on the offset
    assign tri_sum = {2'b00, r1_reg[STATE_W-1:2]} + {2'b00, gen_state_reg[STATE_W-1:2]};
    assign tri_neg = tri_sum < TRI_OFFSET;
    assign tri_mag = tri_neg ? (TRI_OFFSET - tri_sum) : (tri_sum - TRI_OFFSET);

    assign quot     = prod_reg >> SCALE_FRAC_BITS;
    assign clip_mag = (quot > PROD_W'(SAMPLE_LIMIT)) ? SAMPLE_LIMIT : quot[14:0];
    assign clip_ext = {1'b0, clip_mag};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            frame_reg <= s_frame_end;
        end
        if (cmd.lcg_first) begin
            r1_reg <= lcg_step(gen_state_reg);
        end
        if (cmd.amp) begin
            mag_reg <= tri_mag[MAG_W-1:0];
            neg_reg <= tri_neg;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(scale_reg);
        end
        if (cmd.load_out) begin
            sample_reg     <= neg_reg ? signed'(-clip_ext) : signed'(clip_ext);
            frame_last_reg <= frame_reg;
        end
    end

    assign m_noise_sample = sample_reg;
    assign m_frame_last   = frame_last_reg;

endmodule

`default_nettype wire

/* rtl/triangular_noise_generator_unit.sv */
// ----------------------------------------------------------------------------
// Triangular noise generator unit
// Each request on the s_ channel yields one saturated triangular noise sample
// on the m_ channel; frame_end passes through as frame_last.
//
// cfg channel: index 0 writes noise_scale (unsigned, SCALE_FRAC_BITS
// fractional bits), index 1 writes the seed and reloads the generator.
// Other indexes are dropped. cfg_ready is always high; write only when idle.
// After accept, a request passes through two generator steps, the triangle
// sum, a 31x31 scale multiply and saturation into the output register.
// One request at a time: the controller walks it through the shared datapath
// registers one step per cycle, stalling only in the final step.
// s_ready is high while the controller is idle, even if a result still waits
// in the output register; a stalled m_ready holds the next result in the
// final step until the output register is taken.
// Reset: scale 0, generator state 1, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module triangular_noise_generator_unit #(
    parameter int SCALE_FRAC_BITS = 44
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_frame_end,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [tng_pkg::SAMPLE_W-1:0]     m_noise_sample,
    output logic                                    m_frame_last,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tng_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tng_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tng_pkg::*;

    tng_cmd_t cmd;

    assign cfg_ready = 1'b1;

    tng_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tng_datapath #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_frame_end    (s_frame_end),
        .m_noise_sample (m_noise_sample),
        .m_frame_last   (m_frame_last)
    );

endmodule

`default_nettype wire

/* rtl/tng_checker.sv */
// ----------------------------------------------------------------------------
// Triangular noise generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangular_noise_generator_unit_macros.svh"

module tng_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic signed [tng_pkg::SAMPLE_W-1:0] m_noise_sample,
    input wire logic                               m_frame_last,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready
);

    `TNG_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    `TNG_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_noise_sample) && $stable(m_frame_last)), "stalled result changed")

    `TNG_ASSERT(a_no_min_sample, aclk, aresetn, m_valid |-> (m_noise_sample != 16'sh8000), "sample hit -32768")

    `TNG_ASSERT(a_busy_after_req, aclk, aresetn, (s_valid && s_ready) |=> (!s_ready && !$rose(m_valid)), "request not sequenced")

    `TNG_ASSERT(a_cfg_always_ready, aclk, aresetn, cfg_valid |-> cfg_ready, "cfg stalled")

endmodule

bind triangular_noise_generator_unit tng_checker u_tng_checker (.*);

`default_nettype wire

/* verif/tng_noise_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangular noise generator checker
// Watches the request, result and register write channels. It keeps a model of
// the generator and the scale register, predicts one sample per request and
// compares every result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tng_noise_checker #(
    parameter int SCALE_FRAC_BITS = 44
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_frame_end,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [tng_pkg::SAMPLE_W-1:0]  m_noise_sample,
    input  logic                                 m_frame_last,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [tng_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tng_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked_count,
    output int                                   clipped_count
);
    import tng_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       clip;
    } noise_prediction_t;

    noise_prediction_t awaited_samples[$];
    logic [SCALE_W-1:0] scale_model;
    logic [STATE_W-1:0] lcg_model;

    function automatic noise_prediction_t predict_sample(input logic [STATE_W-1:0] r1,
                                                         input logic [STATE_W-1:0] r2,
                                                         input logic [SCALE_W-1:0] scale,
                                                         input logic last);
        noise_prediction_t p;
        longint amp;
        longint unsigned mag;
        longint unsigned level;
        amp = longint'({34'd0, r1[31:2]}) + longint'({34'd0, r2[31:2]})
              - longint'({32'd0, TRI_OFFSET});
        mag = (amp < 0) ? -amp : amp;
        // magnitude and scale both fit 31 bits, so the product stays below 2^62
        level = (mag * {33'd0, scale}) >> SCALE_FRAC_BITS;
        p.clip = level > {49'd0, SAMPLE_LIMIT};
        if (p.clip) begin
            level = {49'd0, SAMPLE_LIMIT};
        end
        p.sample = (amp < 0) ? -$signed(level[SAMPLE_W-1:0]) : $signed(level[SAMPLE_W-1:0]);
        p.last = last;
        return p;
    endfunction

    always @(posedge aclk) begin
        noise_prediction_t want;
        logic [STATE_W-1:0] r1;
        logic [STATE_W-1:0] r2;
        if (!aresetn) begin
            scale_model = '0;
            lcg_model = SEED_RESET;
            awaited_samples.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_samples.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got sample %0d last %0b",
                             $time, m_noise_sample, m_frame_last);
                    fail_count++;
                end else begin
                    want = awaited_samples.pop_front();
                    if (m_noise_sample !== want.sample) begin
                        $display("%0t: noise_sample expected %0d, got %0d",
                                 $time, want.sample, m_noise_sample);
                        fail_count++;
                    end
                    if (m_frame_last !== want.last) begin
                        $display("%0t: frame_last expected %0b, got %0b",
                                 $time, want.last, m_frame_last);
                        fail_count++;
                    end
                    checked_count++;
                    if (want.clip) begin
                        clipped_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NOISE_SCALE: scale_model = cfg_data[SCALE_W-1:0];
                    REG_SEED_VALUE:  lcg_model = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                // two generator steps per request
                lcg_model = lcg_model * LCG_MUL + LCG_ADD;
                r1 = lcg_model;
                lcg_model = lcg_model * LCG_MUL + LCG_ADD;
                r2 = lcg_model;
                awaited_samples.push_back(predict_sample(r1, r2, scale_model, s_frame_end));
            end
            pending <= awaited_samples.size();
        end
    end

endmodule

/* verif/tb_triangular_noise_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangular noise generator testbench
// Directed requests over zero, full and fine scales, reseeds and dropped
// register writes, then random settings with random request and result
// stalls. A checker module beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_triangular_noise_generator_unit;
    import tng_pkg::*;

    localparam int FRAC_BITS      = 44;
    localparam int REQUEST_TARGET = 1700;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef enum {
        SCALE_ZERO,
        SCALE_FULL,
        SCALE_RAW,
        SCALE_LINEAR,
        SCALE_FINE
    } scale_pick_t;

    logic                         aclk;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic                         s_frame_end = 1'b0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0]   m_noise_sample;
    logic                         m_frame_last;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index   = '0;
    logic [CFG_DATA_W-1:0]        cfg_data    = '0;
    logic                         steady      = 1'b0;

    int fail_count;
    int pending;
    int checked_count;
    int clipped_count;
    int requests_sent;
    int register_writes;
    int settings_used;
    int cycle_count;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    triangular_noise_generator_unit #(
        .SCALE_FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_noise_sample (m_noise_sample),
        .m_frame_last   (m_frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    tng_noise_checker #(
        .SCALE_FRAC_BITS(FRAC_BITS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_noise_sample (m_noise_sample),
        .m_frame_last   (m_frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .clipped_count  (clipped_count)
    );

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_noise_request(input logic last);
        while (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_frame_end <= last;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // hold off requests until every outstanding sample has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        register_writes++;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] scale_data, input bit reseed,
                             input logic [CFG_DATA_W-1:0] seed_data, input bit stray);
        wait_for_drain();
        if (stray) begin
            write_register($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, $urandom());
        end
        write_register(REG_NOISE_SCALE, scale_data);
        if (reseed) begin
            write_register(REG_SEED_VALUE, seed_data);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_burst(input int count);
        for (int i = 0; i < count; i++) begin
            send_noise_request($urandom_range(7) == 0);
        end
    endtask

    initial begin
        scale_pick_t pick;
        logic [CFG_DATA_W-1:0] scale_data;
        int phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // scale still zero after reset: all-zero samples, generator runs from seed 1
        send_noise_request(1'b0);
        send_noise_request(1'b1);
        send_noise_request(1'b0);
        settings_used = 1;

        // full scale: clipping on both signs
        configure(32'h7FFF_FFFF, 1'b0, '0, 1'b0);
        send_noise_request(1'b1);
        send_noise_request(1'b0);
        send_noise_request(1'b0);
        send_noise_request(1'b1);

        // top data bit ignored on scale, zero seed, writes to unused indexes dropped
        configure(32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0);
        write_register(REG_UNUSED_2, 32'hFFFF_FFFF);
        write_register(REG_UNUSED_3, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_noise_request(1'b0);
        send_noise_request(1'b1);
        send_noise_request(1'b0);
        send_noise_request(1'b0);

        // nominal level with an all-ones seed
        configure(32'd1315000000, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_burst(5);

        // fine scale: fractional products, truncation on negative values
        configure(32'h0100_0000, 1'b1, 32'h0000_0001, 1'b0);
        send_burst(5);

        phase = 0;
        while (requests_sent < REQUEST_TARGET) begin
            pick = scale_pick_t'($urandom_range(4));
            case (pick)
                SCALE_ZERO:   scale_data = '0;
                SCALE_FULL:   scale_data = 32'h7FFF_FFFF;
                SCALE_RAW:    scale_data = $urandom();
                SCALE_LINEAR: scale_data = $urandom_range(536854528);
                default:      scale_data = $urandom_range(32'h0001_0000);
            endcase
            configure(scale_data, $urandom_range(3) != 0, $urandom(), $urandom_range(3) == 0);
            steady <= (phase == 3);
            for (int i = $urandom_range(220, 80); i > 0; i--) begin
                if ($urandom_range(199) == 0) begin
                    wait_for_drain();
                end
                send_noise_request($urandom_range(7) == 0);
            end
            steady <= 1'b0;
            phase++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d requests over %0d register settings (%0d writes);",
                 requests_sent, settings_used, register_writes);
        $display("%0d samples checked, %0d of them clipped at the limit.",
                 checked_count, clipped_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
